>>> rtl/sme_pkg.sv
// Package for the stack machine execute unit: sizes, opcodes, error codes.
// No dependencies.
package sme_pkg;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned PcBits     = 16;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_IN = 5'd3, OP_OUT = 5'd4,
    OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_PUSHR = 5'd9,
    OP_POPR = 5'd10, OP_JMP = 5'd11, OP_JEQ = 5'd12, OP_JNE = 5'd13, OP_JA = 5'd14,
    OP_JAE = 5'd15, OP_JB = 5'd16, OP_JBE = 5'd17, OP_CALL = 5'd18, OP_RET = 5'd19
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2, ERR_REG = 3'd3, ERR_DIV0 = 3'd4
  } err_e;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;
endpackage

>>> rtl/sme_divider.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg.
module sme_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sme_pkg::div_req_t req_i,
  output sme_pkg::div_rsp_t rsp_o
);
  import sme_pkg::*;
  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, neg_q, done_q;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.a[31] ? (32'd0 - req_i.a) : req_i.a;
      den_q <= req_i.b[31] ? (32'd0 - req_i.b) : req_i.b;
      neg_q <= req_i.a[31] ^ req_i.b[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

>>> rtl/stack_machine_execute.sv
// Top level of the stack machine execute unit: sequencer, stack memory,
// register file and result register. Depends on sme_pkg and sme_divider.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | func, immediate, reg_index, target, in_value (96b)  | -
//  m_axis  | out | next_pc, out_valid, out_value, error_code, depth(64b)| -
//
// One request at a time. States from accept to the next possible accept with no output
// stall: faults found on entry go accept, check, result; simple ops accept, read,
// execute, result; two-read ops and ret add a second read, call a second write, div
// a second read and a wait on the divider, one quotient bit a cycle. One read per cycle
// on the stack memory sets the read states; a low m_axis_tready delays the next accept.
// Reset clears pointer, pc, registers and control; stack contents are undefined.
// A result waits in the output register; a new request is taken only after the
// result has been taken (s_axis_tready low while busy or full).
module stack_machine_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // func[4:0] imm[36:5] reg[40:37] tgt[56:41] in[88:57]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // npc[15:0] ov[16] oval[48:17] err[51:49] depth[60:52]
);
  import sme_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001, ST_RD1 = 7'b0000010, ST_RD2 = 7'b0000100,
    ST_EXE = 7'b0001000, ST_DIV = 7'b0010000, ST_WR2 = 7'b0100000,
    ST_OUT = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  logic [4:0]  func_q;
  logic [31:0] imm_q, inv_q;
  logic [3:0]  ridx_q;
  logic [15:0] tgt_q;
  logic [SpW-1:0] sp_q, base_q;
  logic [PcBits-1:0] pc_q;
  logic [31:0] regs_q [8];
  logic [31:0] b_q;
  logic [31:0] mem [StackDepth];
  logic [31:0] rdata_q;
  logic        rd_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;
  logic        out_v_q;
  logic [63:0] out_q;
  div_req_t    dreq;
  div_rsp_t    drsp;

  sme_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  op_e op;
  assign op = op_e'(func_q);

  // return frame: stack truncated to r6 (signed)
  logic [SpW-1:0] frame;
  always_comb begin
    if (regs_q[6][31]) frame = '0;
    else if (regs_q[6] < {{(32-SpW){1'b0}}, sp_q}) frame = regs_q[6][SpW-1:0];
    else frame = sp_q;
  end

  // pre-checks done on entry to ST_RD1
  err_e chk;
  always_comb begin
    chk = ERR_OK;
    unique case (op)
      OP_PUSH, OP_IN: if (sp_q >= SpW'(StackDepth)) chk = ERR_OVER;
      OP_POP, OP_OUT: if (sp_q < SpW'(1)) chk = ERR_UNDER;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (sp_q < SpW'(2)) chk = ERR_UNDER;
        else if (sp_q >= SpW'(StackDepth)) chk = ERR_OVER;
      end
      OP_PUSHR: begin
        if (ridx_q[3]) chk = ERR_REG;
        else if (sp_q >= SpW'(StackDepth)) chk = ERR_OVER;
      end
      OP_POPR: begin
        if (ridx_q[3]) chk = ERR_REG;
        else if (sp_q < SpW'(1)) chk = ERR_UNDER;
      end
      OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE:
        if (sp_q < SpW'(2)) chk = ERR_UNDER;
      OP_CALL: if (sp_q > SpW'(StackDepth - 2)) chk = ERR_OVER;
      OP_RET: if (frame < SpW'(2)) chk = ERR_UNDER;
      default: chk = ERR_OK;
    endcase
  end

  logic two_rd;
  assign two_rd = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV)
               || (op == OP_JEQ) || (op == OP_JNE) || (op == OP_JA) || (op == OP_JAE)
               || (op == OP_JB) || (op == OP_JBE) || (op == OP_RET);

  // operands in ST_EXE: the last read is still in rdata_q, the top of a
  // two-read op was captured in b_q during ST_RD2
  logic [31:0] op_a, op_b;
  assign op_a = rdata_q;
  assign op_b = two_rd ? b_q : rdata_q;

  logic [31:0] mul_lo;
  assign mul_lo = op_a * op_b;

  logic take;
  always_comb begin
    unique case (op)
      OP_JEQ:  take = op_a == op_b;
      OP_JNE:  take = op_a != op_b;
      OP_JA:   take = $signed(op_a) <  $signed(op_b);
      OP_JAE:  take = $signed(op_a) <= $signed(op_b);
      OP_JB:   take = $signed(op_a) >  $signed(op_b);
      default: take = $signed(op_a) >= $signed(op_b);
    endcase
  end

  logic [PcBits-1:0] pc1, tgt1;
  assign pc1  = pc_q + PcBits'(1);
  assign tgt1 = PcBits'(tgt_q) + PcBits'(1);

  // combinational sequencer outputs
  logic             fin;
  logic [PcBits-1:0] npc;
  logic [SpW-1:0]   nsp;
  logic             nov;
  logic [31:0]      noval;
  err_e             nerr;
  logic             wreg_en, wreg2_en;
  logic [2:0]       wreg_idx;
  logic [31:0]      wreg_data, wreg2_data;

  assign s_axis_tready = (st_q == ST_IDLE) && !out_v_q;

  always_comb begin
    st_d = st_q; rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0;
    wr_data = '0; fin = 1'b0; npc = pc1; nsp = sp_q; nov = 1'b0; noval = '0;
    nerr = ERR_OK; wreg_en = 1'b0; wreg_idx = '0; wreg_data = '0;
    wreg2_en = 1'b0; wreg2_data = '0; dreq = '0;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) st_d = ST_RD1;
      ST_RD1: begin
        if (chk != ERR_OK) begin
          fin = 1'b1; nerr = chk; npc = pc_q;
        end else begin
          rd_en = 1'b1;
          rd_addr = (op == OP_RET) ? AddrW'(frame - SpW'(1)) : AddrW'(sp_q - SpW'(1));
          st_d = two_rd ? ST_RD2 : ST_EXE;
        end
      end
      ST_RD2: begin
        rd_en = 1'b1;
        rd_addr = (op == OP_RET) ? AddrW'(base_q - SpW'(2)) : AddrW'(sp_q - SpW'(2));
        st_d = ST_EXE;
      end
      ST_EXE: begin
        unique case (op)
          OP_PUSH, OP_IN, OP_PUSHR: begin
            wr_en = 1'b1; wr_addr = AddrW'(sp_q);
            wr_data = (op == OP_PUSH) ? imm_q : (op == OP_IN) ? inv_q : regs_q[ridx_q[2:0]];
            nsp = sp_q + SpW'(1); fin = 1'b1;
          end
          OP_POP: begin nsp = sp_q - SpW'(1); fin = 1'b1; end
          OP_OUT: begin nsp = sp_q - SpW'(1); nov = 1'b1; noval = op_b; fin = 1'b1; end
          OP_POPR: begin
            nsp = sp_q - SpW'(1); wreg_en = 1'b1; wreg_idx = ridx_q[2:0];
            wreg_data = op_b; fin = 1'b1;
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            wr_en = 1'b1; wr_addr = AddrW'(sp_q);
            wr_data = (op == OP_ADD) ? op_a + op_b : (op == OP_SUB) ? op_a - op_b
                    : mul_lo;
            nsp = sp_q + SpW'(1); fin = 1'b1;
          end
          OP_DIV: begin
            if (op_b == '0) begin
              fin = 1'b1; nerr = ERR_DIV0; npc = pc_q;
            end else begin
              dreq.start = 1'b1; dreq.a = op_a; dreq.b = op_b; st_d = ST_DIV;
            end
          end
          OP_JMP: begin npc = tgt1; fin = 1'b1; end
          OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
            nsp = sp_q - SpW'(2); if (take) npc = tgt1; fin = 1'b1;
          end
          OP_CALL: begin
            wr_en = 1'b1; wr_addr = AddrW'(sp_q); wr_data = regs_q[6]; st_d = ST_WR2;
          end
          OP_RET: begin
            npc = PcBits'(regs_q[7]) + PcBits'(1); nsp = base_q - SpW'(2);
            wreg_en = 1'b1; wreg_idx = 3'd7; wreg_data = op_b;
            wreg2_en = 1'b1; wreg2_data = op_a; fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      ST_DIV: if (drsp.done) begin
        wr_en = 1'b1; wr_addr = AddrW'(sp_q); wr_data = drsp.q;
        nsp = sp_q + SpW'(1); fin = 1'b1;
      end
      ST_WR2: begin
        wr_en = 1'b1; wr_addr = AddrW'(sp_q + SpW'(1)); wr_data = regs_q[7];
        nsp = sp_q + SpW'(2); npc = tgt1;
        wreg_en = 1'b1; wreg_idx = 3'd7; wreg_data = 32'(pc_q);
        wreg2_en = 1'b1; wreg2_data = 32'(sp_q + SpW'(2)); fin = 1'b1;
      end
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    if (fin) st_d = ST_OUT;
  end

  // stack memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tdata[4:0];
      imm_q  <= s_axis_tdata[36:5];
      ridx_q <= s_axis_tdata[40:37];
      tgt_q  <= s_axis_tdata[56:41];
      inv_q  <= s_axis_tdata[88:57];
    end
    if (st_q == ST_RD1) base_q <= frame;
    if (st_q == ST_RD2) b_q <= rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; sp_q <= '0; pc_q <= '0; out_v_q <= 1'b0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (fin) begin
        sp_q <= nsp; pc_q <= npc; out_v_q <= 1'b1;
        if (wreg_en) regs_q[wreg_idx] <= wreg_data;
        if (wreg2_en) regs_q[6] <= wreg2_data;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) out_q <= {3'd0, 9'(nsp), nerr, noval, nov, 16'(npc)};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SpW'(StackDepth))
    else $error("stack pointer beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !(wr_en && nerr != ERR_OK)) else $error("write on error");
endmodule
